FILE: hdl/ocyl_pkg.sv
// Shared constants, types and helpers for the open cylinder intersection block.
package ocyl_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int SQ_STEPS   = 32;
    localparam int SQ_REM_W   = 33;
    localparam int NUM_W      = 34;
    localparam int MIN_DIST_RST = 66;

    localparam logic [2:0] REG_Y_BOTTOM = 3'd0;
    localparam logic [2:0] REG_Y_TOP    = 3'd1;
    localparam logic [2:0] REG_RADIUS   = 3'd2;
    localparam logic [2:0] REG_RECIP    = 3'd3;
    localparam logic [2:0] REG_MIN_DIST = 3'd4;

    typedef struct packed {
        logic               miss;
        logic [30:0]        a;
        logic signed [31:0] h;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
    } t_sq_side;

    typedef struct packed {
        logic               miss;
        logic [1:0]         pos;
        logic [30:0]        a;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
    } t_dv_side;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] res;
        if (v > 66'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -66'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [31:0] neg_sat32(input logic signed [31:0] v);
        logic signed [31:0] res;
        if (v == 32'sh80000000) begin
            res = 32'sh7FFFFFFF;
        end else begin
            res = -v;
        end
        return res;
    endfunction

endpackage

FILE: hdl/ocyl_sqrt_cell.sv
// One digit step of the pipelined integer square root.
module ocyl_sqrt_cell
    import ocyl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [SQ_REM_W-1:0] i_rem,
    input  logic [31:0]         i_root,
    input  logic [63:0]         i_rad,
    input  t_sq_side            i_side,
    output logic                o_valid,
    output logic [SQ_REM_W-1:0] o_rem,
    output logic [31:0]         o_root,
    output logic [63:0]         o_rad,
    output t_sq_side            o_side
);

    logic [SQ_REM_W+1:0] w_rv;
    logic [SQ_REM_W+1:0] w_trial;
    logic [SQ_REM_W+1:0] w_diff;
    logic                w_ge;
    logic                r_valid;
    logic [SQ_REM_W-1:0] r_rem,  n_rem;
    logic [31:0]         r_root, n_root;
    logic [63:0]         r_rad,  n_rad;
    t_sq_side            r_side;

    assign w_rv    = {i_rem, i_rad[63:62]};
    assign w_trial = {1'b0, i_root, 2'b01};
    assign w_diff  = w_rv - w_trial;
    assign w_ge    = (w_rv >= w_trial);

    always_comb begin
        n_rem  = w_ge ? w_diff[SQ_REM_W-1:0] : w_rv[SQ_REM_W-1:0];
        n_root = {i_root[30:0], w_ge};
        n_rad  = {i_rad[61:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= n_rad;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_rad   = r_rad;
    assign o_side  = r_side;

endmodule

FILE: hdl/ocyl_div_cell.sv
// One quotient bit step of the two-lane pipelined restoring divider.
module ocyl_div_cell
    import ocyl_pkg::*;
#(
    parameter int P_DW = 33 + FRAC_BITS
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [1:0][30:0]     i_rem,
    input  logic [1:0][P_DW-1:0] i_acc,
    input  t_dv_side             i_side,
    output logic                 o_valid,
    output logic [1:0][30:0]     o_rem,
    output logic [1:0][P_DW-1:0] o_acc,
    output t_dv_side             o_side
);

    logic [1:0][31:0]     w_sh;
    logic [1:0][31:0]     w_diff;
    logic [1:0]           w_ge;
    logic                 r_valid;
    logic [1:0][30:0]     r_rem, n_rem;
    logic [1:0][P_DW-1:0] r_acc, n_acc;
    t_dv_side             r_side;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_sh[k]   = {i_rem[k], i_acc[k][P_DW-1]};
            w_diff[k] = w_sh[k] - {1'b0, i_side.a};
            w_ge[k]   = (w_sh[k] >= {1'b0, i_side.a});
            n_rem[k]  = w_ge[k] ? w_diff[k][30:0] : w_sh[k][30:0];
            n_acc[k]  = {i_acc[k][P_DW-2:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_acc  <= n_acc;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_acc   = r_acc;
    assign o_side  = r_side;

endmodule

FILE: hdl/ray_open_cylinder_intersect.sv
// Top level: ray against open y-axis cylinder, fully pipelined.
//
// Input channel (i_s_*): one ray word per accepted beat, origin and direction
// in signed fixed point. Output channel (o_m_*): one result word per ray, in
// order; tuser carries the hit flag, tdata the distance, normal and hit point.
// A miss returns all fields zero.
// Throughput: one ray per cycle while the skid word is free. A ray passes the
// product stages, the 32-cell square root chain, the (33 + P_FRAC_BITS)-cell
// divider chain and the rescale stages before its result reaches tdata.
// Stall: an output register with a skid word parts the two sides; the input
// is still taken while one result waits, and the whole pipeline holds once the
// skid word is occupied.
// Reset (synchronous, active low) empties the pipeline and loads the register
// defaults: planes at -1.0 and +1.0, radius and reciprocal 1.0, min distance 66 raw LSBs.
// The user writes the APB port only while the block is idle; the block does not enforce it. pready is always high.
module ray_open_cylinder_intersect
    import ocyl_pkg::*;
#(
    parameter int P_FRAC_BITS = FRAC_BITS
)
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [191:0] i_s_tdata,  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [191:0] o_m_tdata,  // distance, normal_x, normal_z, point_x, point_y,
                                     // point_z, zero pad
    output logic [0:0]   o_m_tuser,  // hit_found
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int DW = 33 + P_FRAC_BITS;
    localparam logic signed [31:0] ONE_FIX = 32'sd1 <<< P_FRAC_BITS;

    typedef struct packed {
        logic               hit;
        logic [30:0]        distance;
        logic signed [31:0] nx;
        logic signed [31:0] nz;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } t_res;

    // Configuration registers
    logic signed [31:0] r_y_bottom;
    logic signed [31:0] r_y_top;
    logic [30:0]        r_radius;
    logic [30:0]        r_recip;
    logic [30:0]        r_min_dist;
    logic               w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_bottom <= -ONE_FIX;
            r_y_top    <= ONE_FIX;
            r_radius   <= ONE_FIX[30:0];
            r_recip    <= ONE_FIX[30:0];
            r_min_dist <= 31'(MIN_DIST_RST);
        end else if (w_cfg_wr) begin
            case (paddr[4:2])
                REG_Y_BOTTOM: r_y_bottom <= pwdata;
                REG_Y_TOP:    r_y_top    <= pwdata;
                REG_RADIUS:   r_radius   <= pwdata[30:0];
                REG_RECIP:    r_recip    <= pwdata[30:0];
                REG_MIN_DIST: r_min_dist <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_Y_BOTTOM: prdata = r_y_bottom;
            REG_Y_TOP:    prdata = r_y_top;
            REG_RADIUS:   prdata = {1'b0, r_radius};
            REG_RECIP:    prdata = {1'b0, r_recip};
            REG_MIN_DIST: prdata = {1'b0, r_min_dist};
            default:      prdata = 32'd0;
        endcase
    end

    // Flow control
    logic en;
    logic r_skid_v;
    assign en         = ~r_skid_v;
    assign o_s_tready = en;

    // Stage 1: products
    logic               r1_v;
    logic signed [31:0] r1_ox, r1_oy, r1_oz, r1_dx, r1_dy, r1_dz;
    logic signed [63:0] r1_oxdx, r1_ozdz, r1_oxox, r1_ozoz, r1_dxdx, r1_dzdz;
    logic [61:0]        r1_rr;
    logic signed [31:0] w_ox, w_oy, w_oz, w_dx, w_dy, w_dz;

    assign w_ox = i_s_tdata[31:0];
    assign w_oy = i_s_tdata[63:32];
    assign w_oz = i_s_tdata[95:64];
    assign w_dx = i_s_tdata[127:96];
    assign w_dy = i_s_tdata[159:128];
    assign w_dz = i_s_tdata[191:160];

    // Stage 2: a, h, c
    logic               r2_v;
    logic [30:0]        r2_a;
    logic signed [31:0] r2_h, r2_c;
    logic signed [31:0] r2_ox, r2_oy, r2_oz, r2_dx, r2_dy, r2_dz;
    logic [63:0]        w_asum, w_ash;
    logic signed [65:0] w_h66, w_c66;

    assign w_asum = 64'(r1_dxdx) + 64'(r1_dzdz);
    assign w_ash  = w_asum >> P_FRAC_BITS;
    assign w_h66  = 66'(r1_oxdx >>> P_FRAC_BITS) + 66'(r1_ozdz >>> P_FRAC_BITS);
    assign w_c66  = 66'(r1_oxox >>> P_FRAC_BITS) + 66'(r1_ozoz >>> P_FRAC_BITS)
                  - $signed({4'b0, r1_rr >> P_FRAC_BITS});

    // Stage 3: h*h and a*c
    logic               r3_v;
    logic               r3_azero;
    logic signed [63:0] r3_hh, r3_ac;
    t_sq_side           r3_side;

    // Stage 4: discriminant, into the square root chain
    logic               r4_v;
    logic [63:0]        r4_disc;
    t_sq_side           r4_side;
    logic signed [64:0] w_disc;
    t_sq_side           w_sq_in;

    assign w_disc = 65'(r3_hh) - 65'(r3_ac);

    always_comb begin
        w_sq_in      = r3_side;
        w_sq_in.miss = r3_azero | w_disc[64];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_s_tvalid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ox   <= w_ox;
            r1_oy   <= w_oy;
            r1_oz   <= w_oz;
            r1_dx   <= w_dx;
            r1_dy   <= w_dy;
            r1_dz   <= w_dz;
            r1_oxdx <= w_ox * w_dx;
            r1_ozdz <= w_oz * w_dz;
            r1_oxox <= w_ox * w_ox;
            r1_ozoz <= w_oz * w_oz;
            r1_dxdx <= w_dx * w_dx;
            r1_dzdz <= w_dz * w_dz;
            r1_rr   <= r_radius * r_radius;

            r2_a  <= (w_ash > 64'h7FFFFFFF) ? 31'h7FFFFFFF : w_ash[30:0];
            r2_h  <= sat32(w_h66);
            r2_c  <= sat32(w_c66);
            r2_ox <= r1_ox;
            r2_oy <= r1_oy;
            r2_oz <= r1_oz;
            r2_dx <= r1_dx;
            r2_dy <= r1_dy;
            r2_dz <= r1_dz;

            r3_hh         <= r2_h * r2_h;
            r3_ac         <= $signed({1'b0, r2_a}) * r2_c;
            r3_azero      <= (r2_a == 31'd0);
            r3_side.miss  <= 1'b0;
            r3_side.a     <= r2_a;
            r3_side.h     <= r2_h;
            r3_side.ox    <= r2_ox;
            r3_side.oy    <= r2_oy;
            r3_side.oz    <= r2_oz;
            r3_side.dx    <= r2_dx;
            r3_side.dy    <= r2_dy;
            r3_side.dz    <= r2_dz;

            r4_disc      <= w_disc[63:0];
            r4_side      <= w_sq_in;
        end
    end

    // Square root chain
    logic                            sq_v    [0:SQ_STEPS];
    logic [SQ_REM_W-1:0]             sq_rem  [0:SQ_STEPS];
    logic [31:0]                     sq_root [0:SQ_STEPS];
    logic [63:0]                     sq_rad  [0:SQ_STEPS];
    t_sq_side                        sq_side [0:SQ_STEPS];

    assign sq_v[0]    = r4_v;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = r4_disc;
    assign sq_side[0] = r4_side;

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
        ocyl_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[g]),
            .i_rem   (sq_rem[g]),
            .i_root  (sq_root[g]),
            .i_rad   (sq_rad[g]),
            .i_side  (sq_side[g]),
            .o_valid (sq_v[g+1]),
            .o_rem   (sq_rem[g+1]),
            .o_root  (sq_root[g+1]),
            .o_rad   (sq_rad[g+1]),
            .o_side  (sq_side[g+1])
        );
    end

    // Stage 5: root numerators, into the divider chain
    logic                r5_v;
    logic [1:0][DW-1:0]  r5_acc;
    t_dv_side            r5_side;
    logic signed [NUM_W-1:0] w_nh, w_e, w_n1, w_n2;
    t_sq_side            w_sq_end;

    assign w_sq_end = sq_side[SQ_STEPS];
    assign w_nh     = -NUM_W'(w_sq_end.h);
    assign w_e      = $signed({2'b00, sq_root[SQ_STEPS]});
    assign w_n1     = w_nh - w_e;
    assign w_n2     = w_nh + w_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= sq_v[SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_acc[0]      <= {w_n1[NUM_W-2:0], {P_FRAC_BITS{1'b0}}};
            r5_acc[1]      <= {w_n2[NUM_W-2:0], {P_FRAC_BITS{1'b0}}};
            r5_side.miss   <= w_sq_end.miss;
            r5_side.pos[0] <= ~w_n1[NUM_W-1] & (w_n1 != '0);
            r5_side.pos[1] <= ~w_n2[NUM_W-1] & (w_n2 != '0);
            r5_side.a      <= w_sq_end.a;
            r5_side.ox     <= w_sq_end.ox;
            r5_side.oy     <= w_sq_end.oy;
            r5_side.oz     <= w_sq_end.oz;
            r5_side.dx     <= w_sq_end.dx;
            r5_side.dy     <= w_sq_end.dy;
            r5_side.dz     <= w_sq_end.dz;
        end
    end

    // Divider chain
    logic                dv_v    [0:DW];
    logic [1:0][30:0]    dv_rem  [0:DW];
    logic [1:0][DW-1:0]  dv_acc  [0:DW];
    t_dv_side            dv_side [0:DW];

    assign dv_v[0]    = r5_v;
    assign dv_rem[0]  = '0;
    assign dv_acc[0]  = r5_acc;
    assign dv_side[0] = r5_side;

    for (genvar g = 0; g < DW; g++) begin : g_dv
        ocyl_div_cell #(
            .P_DW (DW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_v[g]),
            .i_rem   (dv_rem[g]),
            .i_acc   (dv_acc[g]),
            .i_side  (dv_side[g]),
            .o_valid (dv_v[g+1]),
            .o_rem   (dv_rem[g+1]),
            .o_acc   (dv_acc[g+1]),
            .o_side  (dv_side[g+1])
        );
    end

    // Stage 6: root range checks, y products
    logic               r6_v;
    logic [1:0]         r6_ok;
    logic [1:0][30:0]   r6_t;
    logic signed [63:0] r6_py [0:1];
    logic signed [31:0] r6_ox, r6_oy, r6_oz, r6_dx, r6_dz;
    t_dv_side           w_dv_end;
    logic [1:0][DW-1:0] w_q;
    logic [1:0]         w_tok;

    assign w_dv_end = dv_side[DW];
    assign w_q      = dv_acc[DW];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_tok[k] = w_dv_end.pos[k] & ~w_dv_end.miss
                     & (w_q[k][DW-1:31] == '0) & (w_q[k][30:0] > r_min_dist);
        end
    end

    // Stage 7: plane test, root choice
    logic               r7_v;
    logic               r7_hit;
    logic [30:0]        r7_t;
    logic signed [31:0] r7_py;
    logic signed [31:0] r7_ox, r7_oz, r7_dx, r7_dz;
    logic signed [65:0] w_y [0:1];
    logic [1:0]         w_in;
    logic               w_sel1;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_y[k]  = 66'(r6_oy) + 66'(r6_py[k] >>> P_FRAC_BITS);
            w_in[k] = r6_ok[k] & (w_y[k] > 66'(r_y_bottom)) & (w_y[k] < 66'(r_y_top));
        end
    end

    assign w_sel1 = w_in[0];

    // Stage 8 to 12: hit point, normal, facing products
    logic               r8_v, r9_v, r10_v, r11_v, r12_v;
    logic               r8_hit, r9_hit, r10_hit, r11_hit, r12_hit;
    logic [30:0]        r8_t, r9_t, r10_t, r11_t, r12_t;
    logic signed [31:0] r8_py, r9_py, r10_py, r11_py, r12_py;
    logic signed [31:0] r8_ox, r8_oz;
    logic signed [31:0] r8_dx, r9_dx, r10_dx, r11_dx;
    logic signed [31:0] r8_dz, r9_dz, r10_dz, r11_dz;
    logic signed [63:0] r8_tx, r8_tz;
    logic signed [31:0] r9_px, r9_pz, r10_px, r10_pz, r11_px, r11_pz, r12_px, r12_pz;
    logic signed [63:0] r10_nx, r10_nz;
    logic signed [31:0] r11_nx, r11_nz, r12_nx, r12_nz;
    logic signed [63:0] r12_p1, r12_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v  <= 1'b0;
            r7_v  <= 1'b0;
            r8_v  <= 1'b0;
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
            r11_v <= 1'b0;
            r12_v <= 1'b0;
        end else if (en) begin
            r6_v  <= dv_v[DW];
            r7_v  <= r6_v;
            r8_v  <= r7_v;
            r9_v  <= r8_v;
            r10_v <= r9_v;
            r11_v <= r10_v;
            r12_v <= r11_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_ok    <= w_tok;
            r6_t[0]  <= w_q[0][30:0];
            r6_t[1]  <= w_q[1][30:0];
            r6_py[0] <= $signed({1'b0, w_q[0][30:0]}) * w_dv_end.dy;
            r6_py[1] <= $signed({1'b0, w_q[1][30:0]}) * w_dv_end.dy;
            r6_ox    <= w_dv_end.ox;
            r6_oy    <= w_dv_end.oy;
            r6_oz    <= w_dv_end.oz;
            r6_dx    <= w_dv_end.dx;
            r6_dz    <= w_dv_end.dz;

            r7_hit <= w_in[0] | w_in[1];
            r7_t   <= w_sel1 ? r6_t[0] : r6_t[1];
            r7_py  <= sat32(w_sel1 ? w_y[0] : w_y[1]);
            r7_ox  <= r6_ox;
            r7_oz  <= r6_oz;
            r7_dx  <= r6_dx;
            r7_dz  <= r6_dz;

            r8_hit <= r7_hit;
            r8_t   <= r7_t;
            r8_py  <= r7_py;
            r8_ox  <= r7_ox;
            r8_oz  <= r7_oz;
            r8_dx  <= r7_dx;
            r8_dz  <= r7_dz;
            r8_tx  <= $signed({1'b0, r7_t}) * r7_dx;
            r8_tz  <= $signed({1'b0, r7_t}) * r7_dz;

            r9_hit <= r8_hit;
            r9_t   <= r8_t;
            r9_py  <= r8_py;
            r9_dx  <= r8_dx;
            r9_dz  <= r8_dz;
            r9_px  <= sat32(66'(r8_ox) + 66'(r8_tx >>> P_FRAC_BITS));
            r9_pz  <= sat32(66'(r8_oz) + 66'(r8_tz >>> P_FRAC_BITS));

            r10_hit <= r9_hit;
            r10_t   <= r9_t;
            r10_py  <= r9_py;
            r10_dx  <= r9_dx;
            r10_dz  <= r9_dz;
            r10_px  <= r9_px;
            r10_pz  <= r9_pz;
            r10_nx  <= r9_px * $signed({1'b0, r_recip});
            r10_nz  <= r9_pz * $signed({1'b0, r_recip});

            r11_hit <= r10_hit;
            r11_t   <= r10_t;
            r11_py  <= r10_py;
            r11_dx  <= r10_dx;
            r11_dz  <= r10_dz;
            r11_px  <= r10_px;
            r11_pz  <= r10_pz;
            r11_nx  <= sat32(66'(r10_nx >>> P_FRAC_BITS));
            r11_nz  <= sat32(66'(r10_nz >>> P_FRAC_BITS));

            r12_hit <= r11_hit;
            r12_t   <= r11_t;
            r12_py  <= r11_py;
            r12_px  <= r11_px;
            r12_pz  <= r11_pz;
            r12_nx  <= r11_nx;
            r12_nz  <= r11_nz;
            r12_p1  <= r11_dx * r11_nx;
            r12_p2  <= r11_dz * r11_nz;
        end
    end

    // Final: face the normal towards the ray, blank a miss
    logic signed [64:0] w_dot;
    logic               w_flip;
    t_res               w_res;

    assign w_dot  = 65'(r12_p1) + 65'(r12_p2);
    assign w_flip = ~w_dot[64] & (w_dot != '0);

    always_comb begin
        w_res = '0;
        if (r12_hit) begin
            w_res.hit      = 1'b1;
            w_res.distance = r12_t;
            w_res.nx       = w_flip ? neg_sat32(r12_nx) : r12_nx;
            w_res.nz       = w_flip ? neg_sat32(r12_nz) : r12_nz;
            w_res.px       = r12_px;
            w_res.py       = r12_py;
            w_res.pz       = r12_pz;
        end
    end

    // Output register and skid word
    logic r_out_v;
    t_res r_out, r_skid;
    logic w_take;

    assign w_take = r_out_v & i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || w_take) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= r12_v;
            end
        end else if (r12_v && en) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || w_take) begin
            r_out <= r_skid_v ? r_skid : w_res;
        end else if (en) begin
            r_skid <= w_res;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tuser  = r_out.hit;
    assign o_m_tdata  = {1'b0, r_out.pz, r_out.py, r_out.px, r_out.nz, r_out.nx,
                         r_out.distance};

endmodule
